// ----- hw/rtl/sbsi_pkg.sv -----
`default_nettype none

package sbsi_pkg;

  // Coordinate and fraction formats.
  localparam int CoordW   = 32;
  localparam int FracW    = 17;
  localparam int CodeW    = FracW + 1;
  localparam int Axes     = 3;

  // Pipeline depths: one quotient bit per divider stage.
  localparam int DivSteps = FracW;
  localparam int LaneLat  = DivSteps + 2;
  localparam int PipeLat  = LaneLat + 3;

  // Guard codes keep interval compares exact outside [0, 1].
  localparam logic signed [CodeW-1:0] CodeBelow = -18'sd1;
  localparam logic signed [CodeW-1:0] CodeOne   = 18'sd65536;
  localparam logic signed [CodeW-1:0] CodeAbove = 18'sd65537;
  localparam logic signed [CodeW-1:0] CodeZero  = 18'sd0;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   dir_t;
  typedef logic signed [CodeW-1:0]  code_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    coord_t box_lo_x;
    coord_t box_lo_y;
    coord_t box_lo_z;
    coord_t box_hi_x;
    coord_t box_hi_y;
    coord_t box_hi_z;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [FracW-1:0] entry_fraction;
    coord_t           entry_x;
    coord_t           entry_y;
    coord_t           entry_z;
  } out_t;

  // What one axis lane hands to the merging stage.
  typedef struct packed {
    logic   ok;
    code_t  tl;
    code_t  th;
    dir_t   dir;
    coord_t start;
  } lane_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sbsi_if.sv -----
`default_nettype none

interface sbsi_in_if import sbsi_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbsi_out_if import sbsi_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sbsi_div.sv -----
`default_nettype none

module sbsi_div import sbsi_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [CoordW-1:0] n_i,
  input  wire logic [CoordW-1:0] d_i,
  input  wire logic              below_i,
  input  wire logic              above_i,
  output code_t                  code_o
);

  // Stage registers: remainder, partial quotient, divisor and guard flags.
  logic [CoordW:0]       r_q     [DivSteps+1];
  logic [FracW-1:0]      q_q     [DivSteps+1];
  logic [CoordW-1:0]     d_q     [DivSteps+1];
  logic                  below_q [DivSteps+1];
  logic                  above_q [DivSteps+1];

  // Load stage: the remainder starts as the numerator, below twice the divisor unless guarded.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]     <= {1'b0, n_i};
      q_q[0]     <= '0;
      d_q[0]     <= d_i;
      below_q[0] <= below_i;
      above_q[0] <= above_i;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [CoordW:0] t;
    logic            bit_v;

    if (j == 0) begin : g_first
      assign t = r_q[j];
    end else begin : g_rest
      assign t = {r_q[j][CoordW-1:0], 1'b0};
    end

    assign bit_v = (t >= {1'b0, d_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]     <= bit_v ? (t - {1'b0, d_q[j]}) : t;
        q_q[j+1]     <= {q_q[j][FracW-2:0], bit_v};
        d_q[j+1]     <= d_q[j];
        below_q[j+1] <= below_q[j];
        above_q[j+1] <= above_q[j];
      end
    end
  end

  // Saturate the quotient to the guard codes.
  always_comb begin
    if (below_q[DivSteps]) begin
      code_o = CodeBelow;
    end else if (above_q[DivSteps] || ($signed({1'b0, q_q[DivSteps]}) > CodeOne)) begin
      code_o = CodeAbove;
    end else begin
      code_o = $signed({1'b0, q_q[DivSteps]});
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sbsi_lane.sv -----
`default_nettype none

module sbsi_lane import sbsi_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire coord_t s_i,
  input  wire coord_t e_i,
  input  wire coord_t lo_i,
  input  wire coord_t hi_i,
  output lane_res_t   res_o
);

  coord_t            lo_s, hi_s;
  dir_t              dir;
  logic              zero, inslab, neg;
  logic [CoordW-1:0] dmag;
  dir_t              nl, nh, nl_f, nh_f;
  logic [CoordW:0]   two_d;
  code_t             cl, ch;

  // Order the bounds and form numerators and divisor magnitude.
  always_comb begin
    lo_s   = (lo_i > hi_i) ? hi_i : lo_i;
    hi_s   = (lo_i > hi_i) ? lo_i : hi_i;
    dir    = {e_i[CoordW-1], e_i} - {s_i[CoordW-1], s_i};
    zero   = (dir == '0);
    neg    = dir[CoordW];
    inslab = (s_i >= lo_s) && (s_i <= hi_s);
    dmag   = neg ? CoordW'(-dir) : dir[CoordW-1:0];
    nl     = {lo_s[CoordW-1], lo_s} - {s_i[CoordW-1], s_i};
    nh     = {hi_s[CoordW-1], hi_s} - {s_i[CoordW-1], s_i};
    nl_f   = neg ? -nl : nl;
    nh_f   = neg ? -nh : nh;
    two_d  = {dmag, 1'b0};
  end

  sbsi_div u_div_lo (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .n_i     (nl_f[CoordW-1:0]),
    .d_i     (dmag),
    .below_i (nl_f[CoordW]),
    .above_i (!nl_f[CoordW] && ($unsigned(nl_f) >= two_d)),
    .code_o  (cl)
  );

  sbsi_div u_div_hi (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .n_i     (nh_f[CoordW-1:0]),
    .d_i     (dmag),
    .below_i (nh_f[CoordW]),
    .above_i (!nh_f[CoordW] && ($unsigned(nh_f) >= two_d)),
    .code_o  (ch)
  );

  // Side data travels alongside the dividers.
  coord_t s_q      [DivSteps+1];
  dir_t   dir_q    [DivSteps+1];
  logic   zero_q   [DivSteps+1];
  logic   inslab_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]      <= s_i;
      dir_q[0]    <= dir;
      zero_q[0]   <= zero;
      inslab_q[0] <= inslab;
      for (int k = 0; k < DivSteps; k++) begin
        s_q[k+1]      <= s_q[k];
        dir_q[k+1]    <= dir_q[k];
        zero_q[k+1]   <= zero_q[k];
        inslab_q[k+1] <= inslab_q[k];
      end
    end
  end

  // Order the two slab codes; a flat axis passes only inside its slab.
  lane_res_t res_d;

  always_comb begin
    res_d.start = s_q[DivSteps];
    res_d.dir   = dir_q[DivSteps];
    if (zero_q[DivSteps]) begin
      res_d.ok = inslab_q[DivSteps];
      res_d.tl = CodeBelow;
      res_d.th = CodeAbove;
    end else begin
      res_d.ok = 1'b1;
      res_d.tl = (ch < cl) ? ch : cl;
      res_d.th = (ch < cl) ? cl : ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sbsi_merge.sv -----
`default_nettype none

module sbsi_merge import sbsi_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      en_i,
  input  wire lane_res_t lanes_i [Axes],
  output out_t           res_o
);

  localparam int ProdW = CoordW + CodeW + 1;

  code_t low_d, high_d;
  logic  ok_d;

  // Intersect the three slab intervals with [0, 1].
  always_comb begin
    low_d  = CodeZero;
    high_d = CodeOne;
    ok_d   = 1'b1;
    for (int a = 0; a < Axes; a++) begin
      if (lanes_i[a].tl > low_d)  low_d  = lanes_i[a].tl;
      if (lanes_i[a].th < high_d) high_d = lanes_i[a].th;
      ok_d = ok_d & lanes_i[a].ok;
    end
  end

  logic             hit1_q;
  logic [FracW-1:0] low1_q;
  coord_t           s1_q [Axes];
  dir_t             d1_q [Axes];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit1_q <= ok_d && (low_d <= high_d);
      low1_q <= low_d[FracW-1:0];
      for (int a = 0; a < Axes; a++) begin
        s1_q[a] <= lanes_i[a].start;
        d1_q[a] <= lanes_i[a].dir;
      end
    end
  end

  // Scale each direction by the entry fraction.
  logic signed [ProdW-1:0] prod_q [Axes];
  logic                    hit2_q;
  logic [FracW-1:0]        low2_q;
  coord_t                  s2_q [Axes];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit2_q <= hit1_q;
      low2_q <= low1_q;
      for (int a = 0; a < Axes; a++) begin
        s2_q[a]   <= s1_q[a];
        prod_q[a] <= ProdW'(d1_q[a] * $signed({1'b0, low1_q}));
      end
    end
  end

  // Round half up, then offset from the start point.
  coord_t entry [Axes];

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      logic signed [ProdW-1:0] v;
      v        = prod_q[a] + ProdW'(32768);
      entry[a] = s2_q[a] + coord_t'(v >>> 16);
    end
  end

  out_t res_d;

  always_comb begin
    res_d.hit            = hit2_q;
    res_d.entry_fraction = hit2_q ? low2_q : '0;
    res_d.entry_x        = hit2_q ? entry[0] : '0;
    res_d.entry_y        = hit2_q ? entry[1] : '0;
    res_d.entry_z        = hit2_q ? entry[2] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/segment_box_slab_intersect.sv -----
// Segment versus box slab test, one segment per cycle while the output is not stalled.
// Throughput is set by the pipelined dividers, two in each of the three axis
// lanes.
// The whole pipeline holds while a finished result waits at the output.
// Reset (asynchronous, active low) clears the stage valid bits only.
`default_nettype none

module segment_box_slab_intersect import sbsi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbsi_in_if.sink   in_i,
  sbsi_out_if.source out_o
);

  logic [PipeLat-1:0] vld_q;
  logic               en;

  // Advance everything unless the output holds an untaken result.
  assign en        = !vld_q[PipeLat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], in_i.valid};
    end
  end

  coord_t    s [Axes], e [Axes], lo [Axes], hi [Axes];
  lane_res_t lanes [Axes];

  assign s  = '{in_i.data.start_x, in_i.data.start_y, in_i.data.start_z};
  assign e  = '{in_i.data.end_x, in_i.data.end_y, in_i.data.end_z};
  assign lo = '{in_i.data.box_lo_x, in_i.data.box_lo_y, in_i.data.box_lo_z};
  assign hi = '{in_i.data.box_hi_x, in_i.data.box_hi_y, in_i.data.box_hi_z};

  // One clipping lane per axis.
  for (genvar a = 0; a < Axes; a++) begin : g_lane
    sbsi_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .s_i    (s[a]),
      .e_i    (e[a]),
      .lo_i   (lo[a]),
      .hi_i   (hi[a]),
      .res_o  (lanes[a])
    );
  end

  sbsi_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .lanes_i (lanes),
    .res_o   (out_o.data)
  );

  assign out_o.valid = vld_q[PipeLat-1];

endmodule

`default_nettype wire
